@@ hw/rtl/nmea_pkg.sv @@
package nmea_pkg;

   // Special characters
   localparam logic [7:0] CH_START = 8'h24;   // '$'
   localparam logic [7:0] CH_STAR  = 8'h2A;   // '*'

   localparam int unsigned TYPE_LEN = 5;
   localparam int unsigned DIGITS   = 2;

   localparam logic [2:0] TYPE_LAST  = 3'(TYPE_LEN - 1);
   localparam logic [1:0] DIGIT_LAST = 2'(DIGITS - 1);

   // Default accepted sentence type, first character in the top byte
   localparam logic [39:0] TYPE_RESET = 40'h4750474741;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_TYPE   = 3'd1,
      PH_DATA   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_ACCEPT = 3'd4
   } phase_type;

   // Decoded hex digit: valid flag plus nibble
   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   // Result word fields
   typedef struct packed {
      logic [7:0] payload_length;
      logic [7:0] received_checksum;
      logic [7:0] computed_checksum;
      logic       sentence_ok;
   } result_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid  = 1'b1;
      h.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nibble = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.nibble = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

@@ hw/rtl/nmea_sentence_checker_unit.sv @@
// NMEA sentence checker.
// Input channel req_*: one received ASCII character per word. Result channel
// rsp_*: exactly one result word per character, in order, giving the
// sentence_ok flag, the running XOR checksum, the parsed checksum and the
// payload length after that character.
// csr_we/csr_wdata write the five-character accepted sentence type (first
// character in bits 39:32); write it only while no characters are in flight.
// Pipeline: an input register, then the parser update into the result
// register. A character accepted into the input register is loaded into the
// result register once the output is free. Throughput is one character per
// cycle while the receiver takes the results; a receiver stall holds it.
// Reset (synchronous, active high) empties both registers, sets the parser to
// wait for '$' and restores the sentence type to GPGGA.
// When the receiver stalls, the result word holds, the input register fills,
// and req_tready drops until the result is taken.
module nmea_sentence_checker_unit
   import nmea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [39:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // [0] sentence_ok, [8:1] computed_checksum,
                                     // [16:9] received_checksum,
                                     // [24:17] payload_length, [31:25] zero
);

   logic [39:0] type_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_data_ff, out_data_in;

   phase_type   phase_ff, phase_in;
   logic [2:0]  type_count_ff, type_count_in;
   logic        type_match_ff, type_match_in;
   logic [7:0]  xor_ff, xor_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  length_ff, length_in;

   logic        advance;
   logic        req_take;
   logic [7:0]  want;
   logic        match_next;
   hex_type     hex;
   logic [7:0]  check_shift;

   // Handshake: move the input word on whenever the result slot is free
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

   // Pick the expected type character
   always_comb begin
      case (type_count_ff)
         3'd0:    want = type_ff[39:32];
         3'd1:    want = type_ff[31:24];
         3'd2:    want = type_ff[23:16];
         3'd3:    want = type_ff[15:8];
         default: want = type_ff[7:0];
      endcase
   end

   assign hex         = hex_decode(in_char_ff);
   assign check_shift = {check_ff[3:0], 4'd0};
   assign match_next  = type_match_ff && (in_char_ff == want);

   // Parser update for the character in the input register
   always_comb begin
      phase_in       = phase_ff;
      type_count_in  = type_count_ff;
      type_match_in  = type_match_ff;
      xor_in         = xor_ff;
      digit_count_in = digit_count_ff;
      check_in       = check_ff;
      length_in      = length_ff;
      out_data_in.sentence_ok = 1'b0;
      if (in_char_ff == CH_START) begin
         phase_in       = PH_TYPE;
         type_count_in  = 3'd0;
         type_match_in  = 1'b1;
         xor_in         = 8'd0;
         digit_count_in = 2'd0;
         check_in       = 8'd0;
         length_in      = 8'd0;
      end else begin
         case (phase_ff)
            PH_TYPE: begin
               type_match_in = match_next;
               xor_in        = xor_ff ^ in_char_ff;
               if (length_ff != 8'hFF) length_in = length_ff + 8'd1;
               type_count_in = type_count_ff + 3'd1;
               if (type_count_ff >= TYPE_LAST)
                  phase_in = match_next ? PH_DATA : PH_WAIT;
            end
            PH_DATA: begin
               if (in_char_ff == CH_STAR) begin
                  phase_in = PH_DIGITS;
               end else begin
                  xor_in = xor_ff ^ in_char_ff;
                  if (length_ff != 8'hFF) length_in = length_ff + 8'd1;
               end
            end
            PH_DIGITS: begin
               if (in_char_ff != CH_STAR) begin
                  digit_count_in = digit_count_ff + 2'd1;
                  if (!hex.valid) begin
                     check_in = check_shift;
                     phase_in = PH_WAIT;
                  end else begin
                     check_in = check_shift | {4'd0, hex.nibble};
                     if (digit_count_ff >= DIGIT_LAST)
                        phase_in = ((check_shift | {4'd0, hex.nibble}) == xor_ff)
                                   ? PH_ACCEPT : PH_WAIT;
                  end
               end
            end
            PH_ACCEPT: out_data_in.sentence_ok = 1'b1;
            default: ;
         endcase
      end
      out_data_in.computed_checksum = xor_in;
      out_data_in.received_checksum = check_in;
      out_data_in.payload_length    = length_in;
   end

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff        <= TYPE_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_WAIT;
         type_count_ff  <= 3'd0;
         type_match_ff  <= 1'b1;
         xor_ff         <= 8'd0;
         digit_count_ff <= 2'd0;
         check_ff       <= 8'd0;
         length_ff      <= 8'd0;
      end else begin
         if (csr_we) type_ff <= csr_wdata;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            type_count_ff  <= type_count_in;
            type_match_ff  <= type_match_in;
            xor_ff         <= xor_in;
            digit_count_ff <= digit_count_in;
            check_ff       <= check_in;
            length_ff      <= length_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_char_ff  <= req_tdata;
      if (advance)  out_data_ff <= out_data_in;
   end

`ifndef NO_ASSERTIONS
   a_ok_in_accept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.sentence_ok |-> phase_ff == PH_ACCEPT)
      else $error("sentence_ok reported outside accepting phase");

   a_type_count: assert property (@(posedge clock) disable iff (reset)
      type_count_ff <= 3'(TYPE_LEN))
      else $error("type count overran");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= 2'(DIGITS))
      else $error("digit count overran");

   a_data_matched: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA || phase_ff == PH_DIGITS |-> type_match_ff)
      else $error("data phase entered without type match");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_char_ff == CH_START |=>
         length_ff == 8'd0 && xor_ff == 8'd0 && phase_ff == PH_TYPE)
      else $error("start character did not restart parsing");
`endif

endmodule

@@ sim/nmea_sentence_checker_unit_test.sv @@
module nmea_sentence_checker_unit_test
   import nmea_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_PHASE = 250;
   localparam int NUM_PHASES      = 8;
   localparam int IDLE_PCT        = 56;
   localparam int BOTH_IDLE_PCT   = 7;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int MAX_PRINTED     = 100;

   // Sentence types used across the phases
   localparam logic [39:0] TYPE_GPRMC = 40'h4750524D43;
   localparam logic [39:0] TYPE_GNGSA = 40'h474E475341;
   localparam logic [39:0] TYPE_ZEROS = 40'h0000000000;
   localparam logic [39:0] TYPE_ONES  = 40'hFFFFFFFFFF;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SEND_IDLE,
      FLOW_RECV_STALL,
      FLOW_BOTH
   } flow_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      result_type want;
   } char_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [39:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] char_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [0] sentence_ok, [8:1] computed_checksum,
                               // [16:9] received_checksum, [24:17] payload_length

   // Sentence tracking state, mirrored from the block
   logic [39:0] sentence_type;
   phase_type   parse_phase;
   logic [2:0]  type_cnt;
   logic        type_ok;
   logic [7:0]  xor_sum;
   logic [1:0]  digit_cnt;
   logic [7:0]  check_val;
   logic [7:0]  length_cnt;

   result_type  pending_results[$];
   int          items_sent;
   int          error_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_req;

   nmea_sentence_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
      if (nib < 4'd10) return 8'(int'("0") + nib);
      return 8'((lower ? int'("a") : int'("A")) + nib - 10);
   endfunction

   function automatic result_type make_result(input bit ok, input logic [7:0] comp,
                                              input logic [7:0] recv, input logic [7:0] len);
      result_type r;
      r.sentence_ok       = ok;
      r.computed_checksum = comp;
      r.received_checksum = recv;
      r.payload_length    = len;
      return r;
   endfunction

   // Advance the sentence tracker by one character and return its result word
   function automatic result_type parse_char(input logic [7:0] c);
      result_type  r;
      logic [7:0]  want;
      int          v;
      r.sentence_ok = 1'b0;
      if (c == CH_START) begin
         parse_phase = PH_TYPE;
         type_cnt    = '0;
         type_ok     = 1'b1;
         xor_sum     = '0;
         digit_cnt   = '0;
         check_val   = '0;
         length_cnt  = '0;
      end else begin
         case (parse_phase)
            PH_TYPE: begin
               want = 8'(sentence_type >> (8 * (int'(TYPE_LEN) - 1 - int'(type_cnt))));
               if (c != want) type_ok = 1'b0;
               xor_sum ^= c;
               if (length_cnt != 8'hFF) length_cnt++;
               type_cnt++;
               if (type_cnt >= TYPE_LEN) begin
                  if (type_ok) parse_phase = PH_DATA;
                  else parse_phase = PH_WAIT;
               end
            end
            PH_DATA: begin
               if (c == CH_STAR) begin
                  parse_phase = PH_DIGITS;
               end else begin
                  xor_sum ^= c;
                  if (length_cnt != 8'hFF) length_cnt++;
               end
            end
            PH_DIGITS: begin
               // a repeated asterisk is skipped; a non-hex digit drops the sentence
               if (c != CH_STAR) begin
                  v = hex_value(c);
                  check_val = {check_val[3:0], (v < 0) ? 4'h0 : 4'(v)};
                  digit_cnt++;
                  if (v < 0) begin
                     parse_phase = PH_WAIT;
                  end else if (digit_cnt >= DIGITS) begin
                     if (check_val == xor_sum) parse_phase = PH_ACCEPT;
                     else parse_phase = PH_WAIT;
                  end
               end
            end
            PH_ACCEPT: r.sentence_ok = 1'b1;
            default: ;
         endcase
      end
      r.computed_checksum = xor_sum;
      r.received_checksum = check_val;
      r.payload_length    = length_cnt;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Offer one character, hold it until taken, then log the expected word
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(parse_char(c));
      items_sent++;
   endtask

   // Drain all results, let the pipeline settle, then write the type register
   task automatic write_sentence_type(input logic [39:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we        <= 1'b0;
      sentence_type  = value;
   endtask

   function automatic logic [7:0] random_data_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CH_START || c == CH_STAR);
      return c;
   endfunction

   // One random burst: mostly framed sentences with random content, some noise
   task automatic send_random_burst();
      int          n;
      int          i;
      int          digit_mode;
      logic [7:0]  c;
      logic [7:0]  sum;
      if ($urandom_range(99) < 12) begin
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) send_char(8'($urandom_range(255)));
         return;
      end
      send_char(CH_START);
      // type characters, now and then corrupted
      for (i = 0; i < TYPE_LEN; i++) begin
         c = 8'(sentence_type >> (8 * (int'(TYPE_LEN) - 1 - i)));
         if ($urandom_range(24) == 0) c = 8'($urandom_range(255));
         send_char(c);
      end
      n = ($urandom_range(14) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 20);
      for (i = 0; i < n; i++) send_char(random_data_char());
      send_char(CH_STAR);
      if ($urandom_range(9) == 0) send_char(CH_STAR);
      sum        = xor_sum;
      digit_mode = $urandom_range(9);
      if (digit_mode == 0) sum = sum ^ 8'($urandom_range(1, 255));
      for (i = 0; i < DIGITS; i++) begin
         c = hex_char((i == 0) ? sum[7:4] : sum[3:0], 1'($urandom_range(1)));
         if (digit_mode == 1 && $urandom_range(1) == 0) begin
            do c = 8'($urandom_range(255));
            while (hex_value(c) >= 0 || c == CH_START || c == CH_STAR);
         end
         send_char(c);
      end
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) send_char(random_data_char());
   endtask

   // Result side: check each word, then pick the next ready level
   initial begin
      result_type got;
      result_type want;
      int         hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[24:0]);
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
            end else begin
               want = pending_results.pop_front();
               if (got.sentence_ok != want.sentence_ok)
                  report_mismatch($sformatf("sentence_ok %0d, want %0d",
                                            got.sentence_ok, want.sentence_ok));
               if (got.computed_checksum != want.computed_checksum)
                  report_mismatch($sformatf("computed_checksum %h, want %h",
                                            got.computed_checksum, want.computed_checksum));
               if (got.received_checksum != want.received_checksum)
                  report_mismatch($sformatf("received_checksum %h, want %h",
                                            got.received_checksum, want.received_checksum));
               if (got.payload_length != want.payload_length)
                  report_mismatch($sformatf("payload_length %0d, want %0d",
                                            got.payload_length, want.payload_length));
               if (rsp_tdata[31:25] != '0)
                  report_mismatch($sformatf("pad bits nonzero in %h", rsp_tdata));
            end
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Stop the run if nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("nmea_sentence_checker_unit test failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      char_row_type  directed_rows[27];
      logic [39:0]   phase_types[NUM_PHASES];
      flow_mode_type mode;
      int            phase_end;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      items_sent     = 0;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = 1'b0;

      sentence_type = TYPE_RESET;
      parse_phase   = PH_WAIT;
      type_cnt      = '0;
      type_ok       = 1'b1;
      xor_sum       = '0;
      digit_cnt     = '0;
      check_val     = '0;
      length_cnt    = '0;

      // Valid GPGGA sentence with lowercase checksum, type mismatch with a
      // star among the type characters, then a non-hex checksum digit
      directed_rows = '{
         '{8'h00,    1'b1, make_result(1'b0, 8'h00, 8'h00, 8'd0)},
         '{CH_START, 1'b1, make_result(1'b0, 8'h00, 8'h00, 8'd0)},
         '{"G",      1'b0, '0},
         '{"P",      1'b0, '0},
         '{"G",      1'b0, '0},
         '{"G",      1'b0, '0},
         '{"A",      1'b0, '0},
         '{8'hFF,    1'b0, '0},
         '{CH_STAR,  1'b0, '0},
         '{CH_STAR,  1'b0, '0},
         '{"a",      1'b0, '0},
         '{"9",      1'b1, make_result(1'b0, 8'hA9, 8'hA9, 8'd6)},
         '{8'h00,    1'b1, make_result(1'b1, 8'hA9, 8'hA9, 8'd6)},
         '{CH_START, 1'b1, make_result(1'b0, 8'h00, 8'h00, 8'd0)},
         '{"G",      1'b0, '0},
         '{CH_STAR,  1'b0, '0},
         '{"G",      1'b0, '0},
         '{"G",      1'b0, '0},
         '{"A",      1'b0, '0},
         '{CH_START, 1'b0, '0},
         '{"G",      1'b0, '0},
         '{"P",      1'b0, '0},
         '{"G",      1'b0, '0},
         '{"G",      1'b0, '0},
         '{"A",      1'b0, '0},
         '{CH_STAR,  1'b0, '0},
         '{"g",      1'b0, '0}
      };

      phase_types = '{TYPE_RESET, TYPE_GPRMC, TYPE_ZEROS, TYPE_ONES,
                      {8'($urandom_range(255)), 32'($urandom)}, TYPE_RESET,
                      {8'($urandom_range(255)), 32'($urandom)}, TYPE_GNGSA};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset sentence type
      foreach (directed_rows[i]) begin
         send_char(directed_rows[i].ch);
         if (directed_rows[i].typed)
            pending_results[pending_results.size() - 1] = directed_rows[i].want;
      end

      // Random part, one sentence type and flow mode per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) write_sentence_type(phase_types[p]);
         mode = flow_mode_type'(p % 4);
         case (mode)
            FLOW_FREE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            FLOW_SEND_IDLE: begin
               send_idle_pct  = IDLE_PCT;
               recv_stall_pct = 0;
            end
            FLOW_RECV_STALL: begin
               send_idle_pct  = 0;
               recv_stall_pct = IDLE_PCT;
            end
            default: begin
               send_idle_pct  = BOTH_IDLE_PCT;
               recv_stall_pct = BOTH_IDLE_PCT;
            end
         endcase
         // long receiver hold while the sender keeps offering
         if (p == 1) hold_req = 1'b1;
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) send_random_burst();
      end

      // Drain and let any stray word show up
      req_tvalid    <= 1'b0;
      recv_stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("nmea_sentence_checker_unit test passed");
      end else begin
         $display("nmea_sentence_checker_unit test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/nmea_pkg.sv
hw/rtl/nmea_sentence_checker_unit.sv
sim/nmea_sentence_checker_unit_test.sv
